[rtl/core/idlp_pkg.sv]
// ----------------------------------------------------------------------------
// idlp_pkg
// Shared types, codes and character helpers for the include directive line
// parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package idlp_pkg;

  // Fixed field widths
  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned STATUS_BITS = 3;
  localparam int unsigned ERRCOL_BITS = 16;
  localparam int unsigned KW_LEN      = 7;

  // Input opcodes
  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_EOL  = 1'b1
  } opcode_t;

  // Result kinds
  typedef enum logic {
    RK_PATH    = 1'b0,
    RK_VERDICT = 1'b1
  } result_kind_t;

  // Verdict status codes
  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK        = 3'd0,
    ST_NOQUOTE   = 3'd1,
    ST_UNTERM    = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOBRACKET = 3'd4,
    ST_STRAY     = 3'd5
  } status_t;

  // Line phases
  typedef enum logic [3:0] {
    PH_LEAD     = 4'd0,
    PH_KWSPACE  = 4'd1,
    PH_KEYWORD  = 4'd2,
    PH_AFTERKW  = 4'd3,
    PH_PRESPACE = 4'd4,
    PH_PATH     = 4'd5,
    PH_POST     = 4'd6,
    PH_TAIL     = 4'd7,
    PH_SLASH    = 4'd8,
    PH_COMMENT  = 4'd9,
    PH_NOTDIR   = 4'd10,
    PH_ERROR    = 4'd11
  } phase_t;

  // Character constants
  localparam logic [BYTE_BITS-1:0] CH_LBRACKET = 8'h5B;
  localparam logic [BYTE_BITS-1:0] CH_RBRACKET = 8'h5D;
  localparam logic [BYTE_BITS-1:0] CH_QUOTE    = 8'h22;
  localparam logic [BYTE_BITS-1:0] CH_SLASH    = 8'h2F;
  localparam logic [BYTE_BITS-1:0] CH_UNDER    = 8'h5F;
  localparam logic [BYTE_BITS-1:0] CH_LF       = 8'h0A;
  localparam logic [BYTE_BITS-1:0] CH_CR       = 8'h0D;

  // Input beat
  typedef struct packed {
    opcode_t                opcode;
    logic [BYTE_BITS-1:0]   char_byte;
  } item_t;

  // Output beat
  typedef struct packed {
    result_kind_t           result_kind;
    logic [BYTE_BITS-1:0]   path_byte;
    logic                   directive;
    status_t                status;
    logic [ERRCOL_BITS-1:0] error_column;
  } result_t;

  // Keyword letters "include"
  function automatic logic [BYTE_BITS-1:0] kw_char(input logic [2:0] idx);
    logic [BYTE_BITS-1:0] c;
    case (idx)
      3'd0:    c = 8'h69;  // i
      3'd1:    c = 8'h6E;  // n
      3'd2:    c = 8'h63;  // c
      3'd3:    c = 8'h6C;  // l
      3'd4:    c = 8'h75;  // u
      3'd5:    c = 8'h64;  // d
      3'd6:    c = 8'h65;  // e
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Space, tab, CR
  function automatic logic is_blank(input logic [BYTE_BITS-1:0] c);
    return c inside {8'h20, 8'h09, 8'h0D};
  endfunction

  // Space, tab, VT, FF, CR (no LF)
  function automatic logic is_space_no_lf(input logic [BYTE_BITS-1:0] c);
    return c inside {8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};
  endfunction

  // Letter, digit or underscore
  function automatic logic is_word(input logic [BYTE_BITS-1:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], CH_UNDER};
  endfunction

endpackage

`default_nettype wire

[rtl/core/idlp_core.sv]
// ----------------------------------------------------------------------------
// idlp_core
// Line state registers and the per-beat phase transition. Produces at most
// one result per accepted beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module idlp_core
  import idlp_pkg::*;
#(
  parameter int unsigned COLUMN_BITS = 16
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    accept,
  input  wire item_t   item,
  output logic         res_valid,
  output result_t      res
);

  localparam int unsigned EXT_BITS =
    (COLUMN_BITS > ERRCOL_BITS) ? COLUMN_BITS : ERRCOL_BITS;
  localparam logic [COLUMN_BITS-1:0] COL_MAX = {COLUMN_BITS{1'b1}};

  phase_t                 phase, phase_next;
  logic [2:0]             kw_idx, kw_idx_next;
  logic [COLUMN_BITS-1:0] position, position_next;
  logic [COLUMN_BITS-1:0] bracket_col, bracket_col_next;
  logic [COLUMN_BITS-1:0] slash_col, slash_col_next;
  logic                   path_nonempty, path_nonempty_next;
  status_t                verdict_status, verdict_status_next;
  logic [COLUMN_BITS-1:0] verdict_col, verdict_col_next;

  logic [BYTE_BITS-1:0]   c;
  logic [COLUMN_BITS-1:0] col;
  logic [COLUMN_BITS-1:0] ec;
  logic [EXT_BITS-1:0]    ec_ext;
  status_t                st;
  logic                   dir;

  assign c      = item.char_byte;
  assign col    = (position != COL_MAX) ? position + COLUMN_BITS'(1) : position;
  assign ec_ext = EXT_BITS'(ec);

  // Verdict for the current phase
  always_comb begin
    st  = ST_OK;
    ec  = '0;
    dir = 1'b1;
    case (phase)
      PH_AFTERKW, PH_PRESPACE: begin
        st = ST_NOQUOTE;
        ec = bracket_col;
      end
      PH_PATH: begin
        st = ST_UNTERM;
        ec = bracket_col;
      end
      PH_POST: begin
        st = ST_NOBRACKET;
        ec = bracket_col;
      end
      PH_TAIL, PH_COMMENT: begin
        st = ST_OK;
      end
      PH_SLASH: begin
        st = ST_STRAY;
        ec = slash_col;
      end
      PH_ERROR: begin
        st = verdict_status;
        ec = verdict_col;
      end
      default: begin
        dir = 1'b0;
      end
    endcase
  end

  // Next state and result
  always_comb begin
    phase_next          = phase;
    kw_idx_next         = kw_idx;
    position_next       = position;
    bracket_col_next    = bracket_col;
    slash_col_next      = slash_col;
    path_nonempty_next  = path_nonempty;
    verdict_status_next = verdict_status;
    verdict_col_next    = verdict_col;
    res_valid           = 1'b0;
    res                 = '0;

    if (accept && item.opcode == OP_EOL) begin
      // End of line: emit verdict, clear for next line
      res_valid        = 1'b1;
      res.result_kind  = RK_VERDICT;
      res.directive    = dir;
      res.status       = st;
      res.error_column = (ec_ext > EXT_BITS'(16'hFFFF)) ? 16'hFFFF
                                                         : ec_ext[ERRCOL_BITS-1:0];
      phase_next          = PH_LEAD;
      kw_idx_next         = '0;
      position_next       = '0;
      bracket_col_next    = '0;
      slash_col_next      = '0;
      path_nonempty_next  = 1'b0;
      verdict_status_next = ST_OK;
      verdict_col_next    = '0;
    end else if (accept) begin
      position_next = col;
      case (phase)
        PH_LEAD: begin
          if (!is_blank(c)) begin
            if (c == CH_LBRACKET) begin
              bracket_col_next = col;
              phase_next       = PH_KWSPACE;
            end else begin
              phase_next = PH_NOTDIR;
            end
          end
        end
        PH_KWSPACE: begin
          if (!is_space_no_lf(c)) begin
            if (c == kw_char(3'd0)) begin
              kw_idx_next = 3'd1;
              phase_next  = PH_KEYWORD;
            end else begin
              phase_next = PH_NOTDIR;
            end
          end
        end
        PH_KEYWORD: begin
          if (kw_idx < 3'(KW_LEN) && c == kw_char(kw_idx)) begin
            kw_idx_next = kw_idx + 3'd1;
            if (kw_idx == 3'(KW_LEN - 1)) phase_next = PH_AFTERKW;
          end else begin
            phase_next = PH_NOTDIR;
          end
        end
        PH_AFTERKW, PH_PRESPACE: begin
          if (phase == PH_AFTERKW && is_word(c)) begin
            phase_next = PH_NOTDIR;
          end else begin
            phase_next = PH_PRESPACE;
            if (!is_space_no_lf(c)) begin
              if (c == CH_QUOTE) begin
                phase_next = PH_PATH;
              end else begin
                verdict_status_next = ST_NOQUOTE;
                verdict_col_next    = bracket_col;
                phase_next          = PH_ERROR;
              end
            end
          end
        end
        PH_PATH: begin
          if (c == CH_QUOTE) begin
            if (path_nonempty) begin
              phase_next = PH_POST;
            end else begin
              verdict_status_next = ST_EMPTY;
              verdict_col_next    = bracket_col;
              phase_next          = PH_ERROR;
            end
          end else if (c == CH_LF || c == CH_CR) begin
            verdict_status_next = ST_UNTERM;
            verdict_col_next    = bracket_col;
            phase_next          = PH_ERROR;
          end else begin
            // Path byte goes straight out
            path_nonempty_next = 1'b1;
            res_valid          = 1'b1;
            res.result_kind    = RK_PATH;
            res.path_byte      = c;
          end
        end
        PH_POST: begin
          if (!is_blank(c)) begin
            if (c == CH_RBRACKET) begin
              phase_next = PH_TAIL;
            end else begin
              verdict_status_next = ST_NOBRACKET;
              verdict_col_next    = bracket_col;
              phase_next          = PH_ERROR;
            end
          end
        end
        PH_TAIL: begin
          if (!is_blank(c)) begin
            if (c == CH_SLASH) begin
              slash_col_next = col;
              phase_next     = PH_SLASH;
            end else begin
              verdict_status_next = ST_STRAY;
              verdict_col_next    = col;
              phase_next          = PH_ERROR;
            end
          end
        end
        PH_SLASH: begin
          if (c == CH_SLASH) begin
            phase_next = PH_COMMENT;
          end else begin
            verdict_status_next = ST_STRAY;
            verdict_col_next    = slash_col;
            phase_next          = PH_ERROR;
          end
        end
        default: begin
          // Comment, not a directive, latched error: ignore
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_LEAD;
      kw_idx         <= '0;
      position       <= '0;
      bracket_col    <= '0;
      slash_col      <= '0;
      path_nonempty  <= 1'b0;
      verdict_status <= ST_OK;
      verdict_col    <= '0;
    end else begin
      phase          <= phase_next;
      kw_idx         <= kw_idx_next;
      position       <= position_next;
      bracket_col    <= bracket_col_next;
      slash_col      <= slash_col_next;
      path_nonempty  <= path_nonempty_next;
      verdict_status <= verdict_status_next;
      verdict_col    <= verdict_col_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/idlp_out_reg.sv]
// ----------------------------------------------------------------------------
// idlp_out_reg
// Result register holding one beat for the downstream side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module idlp_out_reg
  import idlp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t load_data,
  output logic         valid,
  input  wire logic    stall,
  output result_t      data
);

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

`default_nettype wire

[rtl/core/include_directive_line_parser.sv]
// ----------------------------------------------------------------------------
// include_directive_line_parser
// Recognizes a text line of the form [include "path"], one character beat at
// a time, emitting path bytes and an end-of-line verdict.
// ----------------------------------------------------------------------------
// The line state updates at the accepting edge of each beat, and any result
// (a path byte, or the verdict on an end-of-line beat) lands in the output
// register on that same edge, so a new beat can be taken every cycle unless
// the input stalls. Results appear in the cycle after the beat.
// The input stalls only while the output register holds a result that the
// downstream side is stalling. Columns count from 1, saturate at
// 2^COLUMN_BITS - 1 and are reported saturated to 16 bits; path bytes of a
// line whose verdict is an error are to be discarded by the consumer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module include_directive_line_parser
  import idlp_pkg::*;
#(
  parameter int unsigned COLUMN_BITS = 16
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_stall,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result
);

  logic    accept;
  logic    res_valid;
  result_t res;

  // Input handshake
  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  idlp_core #(
    .COLUMN_BITS (COLUMN_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  idlp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .load_data (res),
    .valid     (result_valid),
    .stall     (result_stall),
    .data      (result)
  );

endmodule

`default_nettype wire
